### src/hlmm_pkg.sv
// Shared types and constants of the halo lineage membership merge unit.
package hlmm_pkg;

    localparam int COL_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int CNT_W      = 48;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [31:0]      NO_ROW  = 32'hFFFF_FFFF;

    localparam logic [2:0] MODE_RECORD    = 3'd0;
    localparam logic [2:0] MODE_LOAD_HALO = 3'd1;
    localparam logic [2:0] MODE_LOAD_ANC  = 3'd2;
    localparam logic [2:0] MODE_LOAD_ROW  = 3'd3;
    localparam logic [2:0] MODE_READ_MEMB = 3'd4;
    localparam logic [2:0] MODE_READ_CNT  = 3'd5;

    localparam logic [2:0] OUT_HEADER   = 3'd0;
    localparam logic [2:0] OUT_STORED   = 3'd1;
    localparam logic [2:0] OUT_BAD_TYPE = 3'd2;
    localparam logic [2:0] OUT_INVALID  = 3'd3;
    localparam logic [2:0] OUT_NO_ROW   = 3'd4;
    localparam logic [2:0] OUT_LOADED   = 3'd5;
    localparam logic [2:0] OUT_READ     = 3'd6;

    localparam logic [2:0] CNT_BAD_TYPE = 3'd4;
    localparam logic [2:0] CNT_INVALID  = 3'd5;
    localparam logic [2:0] CNT_NO_ROW   = 3'd6;
    localparam logic [2:0] CNT_CONFLICT = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_HALO_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SR_ADDR,
        ST_SR_CMP,
        ST_SR_FIN,
        ST_ROW_RD,
        ST_ROW_CHK,
        ST_COL_RD,
        ST_COL_CAP,
        ST_MERGE,
        ST_WR_RD,
        ST_WR_WR,
        ST_MRD_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic             capture;
        logic [COL_W-1:0] col;
    } trk_ctl_t;

    typedef struct packed {
        logic             cd_v;
        logic             ud_v;
        logic             leads_cur;
        logic             leads_cand;
        logic             cand_wins;
        logic [COL_W-1:0] cd;
    } trk_stat_t;

endpackage

### src/hlmm_cfg_if.sv
// Configuration write channel of the merge unit.
interface hlmm_cfg_if
    import hlmm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### src/hlmm_req_if.sv
// Input item channel of the merge unit.
interface hlmm_req_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  mode;
    logic signed [63:0] first_value;
    logic signed [63:0] second_value;
    logic        [11:0] table_index;
    logic        [2:0]  column;
    logic        [1:0]  type_slot;
    logic signed [63:0] load_value;

    modport source (output valid, output mode, output first_value, output second_value,
                    output table_index, output column, output type_slot,
                    output load_value, input ready);
    modport sink (input valid, input mode, input first_value, input second_value,
                  input table_index, input column, input type_slot,
                  input load_value, output ready);
endinterface

### src/hlmm_rsp_if.sv
// Result channel of the merge unit.
interface hlmm_rsp_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  outcome;
    logic               conflict;
    logic signed [63:0] read_data;
    logic        [47:0] stored_total;

    modport source (output valid, output outcome, output conflict, output read_data,
                    output stored_total, input ready);
    modport sink (input valid, input outcome, input conflict, input read_data,
                  input stored_total, output ready);
endinterface

### src/halo_lineage_membership_merge_unit.sv
// Top level of the halo lineage membership merge unit.
//
// Channel | Direction | Beat carries
// cfg     | in        | register index, write data
// req     | in        | mode, first_value, second_value, table_index, column, type_slot,
//         |           | load_value
// rsp     | out       | outcome, conflict, read_data, stored_total
//
// One item is taken at a time.
// A header runs a binary search over the halo table through its read port.
// A stored member makes two column passes over the memory ports.
// After reset a clearing pass over the row and membership tables runs first.
// A finished result waits in the output register while rsp is stalled.
module halo_lineage_membership_merge_unit
    import hlmm_pkg::*;
#(
    parameter int MAX_HALOS = 1024,
    parameter int MAX_DEPTH = 8,
    parameter int MAX_PIDS  = 4096,
    parameter int MAX_ROWS  = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    hlmm_cfg_if.sink    cfg,
    hlmm_req_if.sink    req,
    hlmm_rsp_if.source  rsp
);

    localparam int HW     = (MAX_HALOS > 1) ? $clog2(MAX_HALOS) : 1;
    localparam int NW     = $clog2(MAX_HALOS + 1);
    localparam int ANC_N  = MAX_HALOS * MAX_DEPTH;
    localparam int ROW_N  = 4 * MAX_PIDS;
    localparam int MEMB_N = 4 * MAX_ROWS * MAX_DEPTH;
    localparam int AAW    = $clog2(ANC_N);
    localparam int RAW    = $clog2(ROW_N);
    localparam int MAW    = $clog2(MEMB_N);
    localparam int CLR_N  = (ROW_N > MEMB_N) ? ROW_N : MEMB_N;
    localparam int CLW    = $clog2(CLR_N + 1);

    state_t state_reg, state_next;

    logic [10:0]      halo_count_reg;
    logic [11:0]      max_pid_reg;
    logic [3:0]       depth_reg;
    logic [63:0]      particles_left_reg, particles_left_next;
    logic             halo_valid_reg, halo_valid_next;
    logic [HW-1:0]    halo_idx_reg, halo_idx_next;
    logic [AAW-1:0]   anc_base_reg, anc_base_next;
    logic [MAW-1:0]   memb_base_reg, memb_base_next;
    logic [NW-1:0]    lo_reg, lo_next, hi_reg, hi_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [CLW-1:0]   clr_reg;
    logic [1:0]       mslot_reg, mslot_next;

    logic [2:0]  mode_reg;
    logic [63:0] first_reg, second_reg, load_reg;
    logic [11:0] idx_reg;
    logic [2:0]  column_reg;
    logic [1:0]  slot_reg;

    logic [2:0]  outcome_reg, outcome_next;
    logic        conf_reg, conf_next;
    logic [63:0] data_reg, data_next;

    logic [CNT_W-1:0] cnt_reg [8];
    logic [7:0]       cnt_inc;
    logic [CNT_W-1:0] stored_reg;
    logic             stored_inc;

    logic        out_valid_reg;
    logic [2:0]  out_outcome_reg;
    logic        out_conf_reg;
    logic [63:0] out_data_reg;
    logic [CNT_W-1:0] out_stored_reg;

    logic [63:0]    halo_mem [MAX_HALOS];
    logic [31:0]    anc_mem  [ANC_N];
    logic [31:0]    row_mem  [ROW_N];
    logic [31:0]    memb_mem [MEMB_N];
    logic [63:0]    halo_rdata;
    logic [31:0]    anc_rdata, row_rdata, memb_rdata;
    logic           halo_we, anc_we, row_we, memb_we;
    logic [HW-1:0]  halo_waddr, halo_raddr;
    logic [AAW-1:0] anc_waddr, anc_raddr;
    logic [RAW-1:0] row_waddr, row_raddr;
    logic [MAW-1:0] memb_waddr, memb_raddr;
    logic [31:0]    row_wdata, memb_wdata;

    trk_ctl_t  trk_ctl;
    trk_stat_t trk_stat;

    logic [NW-1:0]    n_used, mid;
    logic [COL_W-1:0] w_used;
    logic             slot_ok, pid_bad, row_missing, take, incomparable, out_free;
    logic [1:0]       slot_map;

    hlmm_lineage_cmp u_cmp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (trk_ctl),
        .cand  (anc_rdata),
        .cur   (memb_rdata),
        .stat  (trk_stat)
    );

    always_comb
    begin
        n_used = (32'(halo_count_reg) > MAX_HALOS) ? NW'(MAX_HALOS) : NW'(halo_count_reg);
        w_used = (32'(depth_reg) > MAX_DEPTH) ? COL_W'(MAX_DEPTH) : COL_W'(depth_reg);
        mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
        slot_ok  = 1'b1;
        slot_map = 2'd0;
        case (second_reg)
            64'd0: slot_map = 2'd0;
            64'd1: slot_map = 2'd1;
            64'd4: slot_map = 2'd2;
            64'd5: slot_map = 2'd3;
            default: slot_ok = 1'b0;
        endcase
        pid_bad = !halo_valid_reg || first_reg[63] || (first_reg > 64'(max_pid_reg))
                  || (first_reg >= 64'(MAX_PIDS));
        row_missing  = (row_rdata == NO_ROW) || (row_rdata >= 32'(MAX_ROWS));
        incomparable = trk_stat.ud_v && !trk_stat.leads_cur && !trk_stat.leads_cand;
        take = trk_stat.cd_v && (!trk_stat.ud_v || trk_stat.leads_cur
               || (incomparable && trk_stat.cand_wins));
        out_free = !out_valid_reg || rsp.ready;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CLW'(CLR_N - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (mode_reg)
                    MODE_RECORD:
                    begin
                        if (particles_left_reg == 64'd0)
                        begin
                            state_next = ST_SR_ADDR;
                        end
                        else if (!slot_ok || pid_bad)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_ROW_RD;
                        end
                    end
                    MODE_READ_MEMB:
                    begin
                        if ((32'(idx_reg) < MAX_ROWS) && (32'(column_reg) < MAX_DEPTH))
                        begin
                            state_next = ST_MRD_WAIT;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_SR_ADDR: state_next = (lo_reg < hi_reg) ? ST_SR_CMP : ST_SR_FIN;
            ST_SR_CMP:  state_next = ST_SR_ADDR;
            ST_SR_FIN:  state_next = ST_DONE;
            ST_ROW_RD:  state_next = ST_ROW_CHK;
            ST_ROW_CHK:
            begin
                if (row_missing)
                begin
                    state_next = ST_DONE;
                end
                else if (w_used == '0)
                begin
                    state_next = ST_MERGE;
                end
                else
                begin
                    state_next = ST_COL_RD;
                end
            end
            ST_COL_RD:  state_next = ST_COL_CAP;
            ST_COL_CAP: state_next = (col_reg + 1'b1 >= w_used) ? ST_MERGE : ST_COL_RD;
            ST_MERGE:   state_next = take ? ST_WR_RD : ST_DONE;
            ST_WR_RD:   state_next = ST_WR_WR;
            ST_WR_WR:   state_next = (col_reg + 1'b1 >= w_used) ? ST_DONE : ST_WR_RD;
            ST_MRD_WAIT: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory ports and comparator control.
    always_comb
    begin
        halo_we    = (state_reg == ST_EXEC) && (mode_reg == MODE_LOAD_HALO)
                     && (32'(idx_reg) < MAX_HALOS);
        halo_waddr = HW'(idx_reg);
        halo_raddr = (lo_reg < hi_reg) ? HW'(mid) : HW'(lo_reg);

        anc_we    = (state_reg == ST_EXEC) && (mode_reg == MODE_LOAD_ANC)
                    && (32'(idx_reg) < MAX_HALOS) && (32'(column_reg) < MAX_DEPTH);
        anc_waddr = AAW'(32'(idx_reg) * MAX_DEPTH + 32'(column_reg));
        anc_raddr = anc_base_reg + AAW'(col_reg);

        row_we    = 1'b0;
        row_waddr = RAW'(32'(slot_reg) * MAX_PIDS + 32'(idx_reg));
        row_wdata = load_reg[31:0];
        if (state_reg == ST_CLEAR)
        begin
            row_we    = (32'(clr_reg) < ROW_N);
            row_waddr = RAW'(clr_reg);
            row_wdata = NO_ROW;
        end
        else if ((state_reg == ST_EXEC) && (mode_reg == MODE_LOAD_ROW))
        begin
            row_we = (32'(idx_reg) < MAX_PIDS);
        end
        row_raddr = RAW'(32'(mslot_reg) * MAX_PIDS + 32'(first_reg[RAW-1:0]));

        memb_we    = 1'b0;
        memb_waddr = memb_base_reg + MAW'(col_reg);
        memb_wdata = (col_reg <= trk_stat.cd) ? anc_rdata : 32'hFFFF_FFFF;
        if (state_reg == ST_CLEAR)
        begin
            memb_we    = (32'(clr_reg) < MEMB_N);
            memb_waddr = MAW'(clr_reg);
            memb_wdata = 32'hFFFF_FFFF;
        end
        else if (state_reg == ST_WR_WR)
        begin
            memb_we = 1'b1;
        end
        if (state_reg == ST_EXEC)
        begin
            memb_raddr = MAW'((32'(slot_reg) * MAX_ROWS + 32'(idx_reg)) * MAX_DEPTH
                              + 32'(column_reg));
        end
        else
        begin
            memb_raddr = memb_base_reg + MAW'(col_reg);
        end

        trk_ctl.start   = (state_reg == ST_ROW_CHK);
        trk_ctl.capture = (state_reg == ST_COL_CAP);
        trk_ctl.col     = col_reg;
    end

    // Datapath next values.
    always_comb
    begin
        particles_left_next = particles_left_reg;
        halo_valid_next     = halo_valid_reg;
        halo_idx_next       = halo_idx_reg;
        anc_base_next       = anc_base_reg;
        memb_base_next      = memb_base_reg;
        lo_next             = lo_reg;
        hi_next             = hi_reg;
        col_next            = col_reg;
        mslot_next          = mslot_reg;
        outcome_next        = outcome_reg;
        conf_next           = conf_reg;
        data_next           = data_reg;
        cnt_inc             = '0;
        stored_inc          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                outcome_next = OUT_READ;
                conf_next    = 1'b0;
                data_next    = '0;
            end
            ST_EXEC:
            begin
                case (mode_reg)
                    MODE_RECORD:
                    begin
                        if (particles_left_reg == 64'd0)
                        begin
                            particles_left_next = first_reg;
                            lo_next             = '0;
                            hi_next             = n_used;
                            outcome_next        = OUT_HEADER;
                        end
                        else
                        begin
                            particles_left_next = particles_left_reg - 64'd1;
                            mslot_next          = slot_map;
                            if (!slot_ok)
                            begin
                                cnt_inc[CNT_BAD_TYPE] = 1'b1;
                                outcome_next          = OUT_BAD_TYPE;
                            end
                            else if (pid_bad)
                            begin
                                cnt_inc[CNT_INVALID] = 1'b1;
                                outcome_next         = OUT_INVALID;
                            end
                        end
                    end
                    MODE_LOAD_HALO: outcome_next = OUT_LOADED;
                    MODE_LOAD_ANC:  outcome_next = OUT_LOADED;
                    MODE_LOAD_ROW:  outcome_next = OUT_LOADED;
                    MODE_READ_CNT:
                    begin
                        if (idx_reg < 12'd8)
                        begin
                            data_next = 64'(cnt_reg[idx_reg[2:0]]);
                        end
                    end
                    default: outcome_next = OUT_READ;
                endcase
            end
            ST_SR_CMP:
            begin
                if ($signed(halo_rdata) < $signed(second_reg))
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
            end
            ST_SR_FIN:
            begin
                halo_valid_next = (lo_reg < n_used) && (halo_rdata == second_reg);
                halo_idx_next   = HW'(lo_reg);
                anc_base_next   = AAW'(32'(HW'(lo_reg)) * MAX_DEPTH);
            end
            ST_ROW_CHK:
            begin
                col_next = '0;
                memb_base_next = MAW'((32'(mslot_reg) * MAX_ROWS + 32'(row_rdata[MAW-1:0]))
                                      * MAX_DEPTH);
                if (row_missing)
                begin
                    cnt_inc[CNT_NO_ROW] = 1'b1;
                    outcome_next        = OUT_NO_ROW;
                end
            end
            ST_COL_CAP:
            begin
                col_next = col_reg + 1'b1;
            end
            ST_MERGE:
            begin
                col_next         = '0;
                outcome_next     = OUT_STORED;
                cnt_inc[mslot_reg] = 1'b1;
                stored_inc       = 1'b1;
                if (trk_stat.cd_v && incomparable)
                begin
                    conf_next             = 1'b1;
                    cnt_inc[CNT_CONFLICT] = 1'b1;
                end
            end
            ST_WR_WR:
            begin
                col_next = col_reg + 1'b1;
            end
            ST_MRD_WAIT:
            begin
                data_next = {{32{memb_rdata[31]}}, memb_rdata};
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (halo_we)
        begin
            halo_mem[halo_waddr] <= load_reg;
        end
        halo_rdata <= halo_mem[halo_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (anc_we)
        begin
            anc_mem[anc_waddr] <= load_reg[31:0];
        end
        anc_rdata <= anc_mem[anc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_rdata <= row_mem[row_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (memb_we)
        begin
            memb_mem[memb_waddr] <= memb_wdata;
        end
        memb_rdata <= memb_mem[memb_raddr];
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && req.valid)
        begin
            mode_reg   <= req.mode;
            first_reg  <= req.first_value;
            second_reg <= req.second_value;
            idx_reg    <= req.table_index;
            column_reg <= req.column;
            slot_reg   <= req.type_slot;
            load_reg   <= req.load_value;
        end
        halo_idx_reg  <= halo_idx_next;
        anc_base_reg  <= anc_base_next;
        memb_base_reg <= memb_base_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mslot_reg     <= mslot_next;
        outcome_reg   <= outcome_next;
        conf_reg      <= conf_next;
        data_reg      <= data_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_outcome_reg <= outcome_reg;
            out_conf_reg    <= conf_reg;
            out_data_reg    <= data_reg;
            out_stored_reg  <= stored_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            clr_reg            <= '0;
            halo_count_reg     <= 11'd0;
            max_pid_reg        <= 12'd4095;
            depth_reg          <= 4'd8;
            particles_left_reg <= '0;
            halo_valid_reg     <= 1'b0;
            col_reg            <= '0;
            stored_reg         <= '0;
            out_valid_reg      <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg          <= state_next;
            particles_left_reg <= particles_left_next;
            halo_valid_reg     <= halo_valid_next;
            col_reg            <= col_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_HALO_COUNT: halo_count_reg <= cfg.data[10:0];
                    CFG_MAX_PID:    max_pid_reg    <= cfg.data[11:0];
                    CFG_DEPTH:      depth_reg      <= cfg.data[3:0];
                    default:        halo_count_reg <= halo_count_reg;
                endcase
            end
            for (int i = 0; i < 8; i++)
            begin
                if (cnt_inc[i] && (cnt_reg[i] != CNT_MAX))
                begin
                    cnt_reg[i] <= cnt_reg[i] + 1'b1;
                end
            end
            if (stored_inc && (stored_reg != CNT_MAX))
            begin
                stored_reg <= stored_reg + 1'b1;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg.ready        = 1'b1;
    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.outcome      = out_outcome_reg;
    assign rsp.conflict     = out_conf_reg;
    assign rsp.read_data    = out_data_reg;
    assign rsp.stored_total = out_stored_reg;

endmodule

### src/hlmm_lineage_cmp.sv
// Column-serial lineage comparator that tracks depths and the first mismatch.
module hlmm_lineage_cmp
    import hlmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  trk_ctl_t    ctl,
    input  logic [31:0] cand,
    input  logic [31:0] cur,
    output trk_stat_t   stat
);

    logic             cd_v_reg, ud_v_reg, fm_v_reg;
    logic [COL_W-1:0] cd_reg, ud_reg, fm_reg;
    logic [31:0]      cand_last_reg, cur_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_v_reg      <= 1'b0;
            ud_v_reg      <= 1'b0;
            fm_v_reg      <= 1'b0;
            cd_reg        <= '0;
            ud_reg        <= '0;
            fm_reg        <= '0;
            cand_last_reg <= '0;
            cur_last_reg  <= '0;
        end
        else if (ctl.start)
        begin
            cd_v_reg <= 1'b0;
            ud_v_reg <= 1'b0;
            fm_v_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            if (!cand[31])
            begin
                cd_v_reg      <= 1'b1;
                cd_reg        <= ctl.col;
                cand_last_reg <= cand;
            end
            if (!cur[31])
            begin
                ud_v_reg     <= 1'b1;
                ud_reg       <= ctl.col;
                cur_last_reg <= cur;
            end
            if (!fm_v_reg && (cand != cur))
            begin
                fm_v_reg <= 1'b1;
                fm_reg   <= ctl.col;
            end
        end
    end

    always_comb
    begin
        stat.cd_v       = cd_v_reg;
        stat.ud_v       = ud_v_reg;
        stat.leads_cur  = (ud_reg <= cd_reg) && (!fm_v_reg || (fm_reg > ud_reg));
        stat.leads_cand = (cd_reg <= ud_reg) && (!fm_v_reg || (fm_reg > cd_reg));
        stat.cand_wins  = (cd_reg > ud_reg) || ((cd_reg == ud_reg)
                          && ($signed(cand_last_reg) < $signed(cur_last_reg)));
        stat.cd         = cd_reg;
    end

endmodule
